// ===== src/pcss_pkg.sv =====
// pcss_pkg: shared types and constants for the priority color source select block
// used by every module under src

package pcss_pkg;

    localparam int DEF_LEVELS   = 4;
    localparam int TIMEOUT_REGS = 4;
    localparam int TO_IDX_W     = 2;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int COLOR_W      = 32;
    localparam int TIME_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int LVL_OUT_W    = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // one finished selection waiting for the output register
    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [LVL_OUT_W-1:0] level;
        logic                 shown;
    } t_result;

endpackage

// ===== src/pcss_cfg.sv =====
// pcss_cfg: APB register file holding the per-level timeouts
// depends on pcss_pkg

module pcss_cfg
    import pcss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    input  logic [TO_IDX_W-1:0]     i_rd_idx,
    output logic [TIME_W-1:0]       o_timeout
);

    logic [TIME_W-1:0] r_timeout [TIMEOUT_REGS];
    logic [TO_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[TO_IDX_W+1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TIMEOUT_REGS; k++) begin
                r_timeout[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_timeout[reg_idx] <= pwdata;
        end
    end

    assign prdata    = r_timeout[reg_idx];
    assign o_timeout = r_timeout[i_rd_idx];

endmodule

// ===== src/pcss_store.sv =====
// pcss_store: per-level color, write time and written flag
// depends on pcss_pkg

module pcss_store
    import pcss_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [LVL_W-1:0]   i_wr_idx,
    input  logic [COLOR_W-1:0] i_wr_color,
    input  logic [TIME_W-1:0]  i_wr_time,
    input  logic [LVL_W-1:0]   i_rd_idx,
    output logic [COLOR_W-1:0] o_rd_color,
    output logic [TIME_W-1:0]  o_rd_time,
    output logic               o_rd_written
);

    logic [COLOR_W-1:0] r_color   [LEVELS];
    logic [TIME_W-1:0]  r_time    [LEVELS];
    logic [LEVELS-1:0]  r_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_color[i_wr_idx] <= i_wr_color;
            r_time[i_wr_idx]  <= i_wr_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_color   = r_color[i_rd_idx];
    assign o_rd_time    = r_time[i_rd_idx];
    assign o_rd_written = r_written[i_rd_idx];

endmodule

// ===== src/pcss_expiry_unit.sv =====
// pcss_expiry_unit: shared elapsed-time subtract and timeout compare
// depends on pcss_pkg

module pcss_expiry_unit
    import pcss_pkg::*;
(
    input  logic              i_written,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_wr_time,
    input  logic [TIME_W-1:0] i_timeout,
    output logic              o_active
);

    logic [TIME_W-1:0] elapsed;

    // wrapping subtraction modulo 2^32
    assign elapsed  = i_now - i_wr_time;
    assign o_active = i_written && ((i_timeout == '0) || (elapsed <= i_timeout));

endmodule

// ===== src/priority_color_source_select_core.sv =====
// a transaction runs from ST_IDLE through ST_SCAN and ST_DONE into the output register; one shared
// expiry unit checks one level per cycle, stopping at the first active level.
// one input transaction per scan: the next one is accepted only once the core is back in ST_IDLE.
// the output register lets the next transaction start while a result waits.
// reset (synchronous, active low) clears timeouts, written flags, the sequencer state and the output valid flag.
// depends on pcss_pkg, pcss_cfg, pcss_store, pcss_expiry_unit

module priority_color_source_select_core
    import pcss_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LVL_OUT_W-1:0]  i_level,
    input  logic [BYTE_W-1:0]     i_red_in,
    input  logic [BYTE_W-1:0]     i_green_in,
    input  logic [BYTE_W-1:0]     i_blue_in,
    input  logic [BYTE_W-1:0]     i_white_in,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_W-1:0]     o_red_out,
    output logic [BYTE_W-1:0]     o_green_out,
    output logic [BYTE_W-1:0]     o_blue_out,
    output logic [BYTE_W-1:0]     o_white_out,
    output logic [LVL_OUT_W-1:0]  o_winning_level,
    output logic                  o_shown
);

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int EXT_W = LVL_W + LVL_OUT_W;

    t_state  r_state, n_state;
    logic    [LVL_W-1:0]  r_idx, n_idx;
    logic    [TIME_W-1:0] r_now;
    t_result r_res, n_res;
    t_result r_out;
    logic    r_out_valid;

    logic              accept;
    logic [EXT_W-1:0]  lvl_ext;
    logic              wr_en;
    logic [EXT_W-1:0]  idx_ext;
    logic [COLOR_W-1:0] rd_color;
    logic [TIME_W-1:0] rd_time;
    logic              rd_written;
    logic [TIME_W-1:0] cfg_timeout;
    logic [TIME_W-1:0] timeout;
    logic              active;
    logic              last_idx;
    logic              scan_end;
    logic              out_free;
    logic              out_load;

    assign accept   = i_valid && !o_stall;
    assign lvl_ext  = EXT_W'(i_level);
    assign wr_en    = accept && (lvl_ext < EXT_W'(LEVELS));
    assign idx_ext  = EXT_W'(r_idx);
    assign last_idx = (r_idx == LVL_W'(LEVELS - 1));
    assign out_free = !r_out_valid || !i_stall;

    pcss_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_rd_idx  (idx_ext[TO_IDX_W-1:0]),
        .o_timeout (cfg_timeout)
    );

    pcss_store #(
        .LEVELS (LEVELS),
        .LVL_W  (LVL_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_idx     (lvl_ext[LVL_W-1:0]),
        .i_wr_color   ({i_white_in, i_blue_in, i_green_in, i_red_in}),
        .i_wr_time    (i_now_ms),
        .i_rd_idx     (r_idx),
        .o_rd_color   (rd_color),
        .o_rd_time    (rd_time),
        .o_rd_written (rd_written)
    );

    // levels without a timeout register never expire
    assign timeout = (idx_ext < EXT_W'(TIMEOUT_REGS)) ? cfg_timeout : '0;

    pcss_expiry_unit u_unit (
        .i_written (rd_written),
        .i_now     (r_now),
        .i_wr_time (rd_time),
        .i_timeout (timeout),
        .o_active  (active)
    );

    assign scan_end = (r_state == ST_SCAN) && (active || last_idx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        n_idx    = r_idx;
        n_res    = r_res;
        out_load = 1'b0;
        o_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                n_idx   = '0;
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_res.shown = active;
                    n_res.color = active ? rd_color : '0;
                    n_res.level = active ? idx_ext[LVL_OUT_W-1:0] : '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
        if (accept) begin
            r_now <= i_now_ms;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_red_out       = r_out.color[BYTE_W-1:0];
    assign o_green_out     = r_out.color[2*BYTE_W-1:BYTE_W];
    assign o_blue_out      = r_out.color[3*BYTE_W-1:2*BYTE_W];
    assign o_white_out     = r_out.color[4*BYTE_W-1:3*BYTE_W];
    assign o_winning_level = r_out.level;
    assign o_shown         = r_out.shown;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for priority_color_source_select_core: directed and random color writes,
// checked against an in-line priority/timeout predictor; depends on pcss_pkg and the core

module testbench
    import pcss_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 7;
    localparam int PHASE_WRITES   = 120;

    // timeout register indexes, one per priority level
    typedef enum int {
        REG_TIMEOUT_L0,
        REG_TIMEOUT_L1,
        REG_TIMEOUT_L2,
        REG_TIMEOUT_L3
    } t_timeout_reg;

    typedef struct {
        logic [LVL_OUT_W-1:0] level;
        logic [BYTE_W-1:0]    red;
        logic [BYTE_W-1:0]    green;
        logic [BYTE_W-1:0]    blue;
        logic [BYTE_W-1:0]    white;
        logic [TIME_W-1:0]    now_ms;
    } t_color_write;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [LVL_OUT_W-1:0] i_level = '0;
    logic [BYTE_W-1:0]    i_red_in = '0;
    logic [BYTE_W-1:0]    i_green_in = '0;
    logic [BYTE_W-1:0]    i_blue_in = '0;
    logic [BYTE_W-1:0]    i_white_in = '0;
    logic [TIME_W-1:0]    i_now_ms = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [BYTE_W-1:0]    o_red_out;
    logic [BYTE_W-1:0]    o_green_out;
    logic [BYTE_W-1:0]    o_blue_out;
    logic [BYTE_W-1:0]    o_white_out;
    logic [LVL_OUT_W-1:0] o_winning_level;
    logic                 o_shown;

    t_color_write pending_writes[$];
    t_result      expected_colors[$];

    // predictor state
    logic [COLOR_W-1:0] stored_color[DEF_LEVELS];
    logic [TIME_W-1:0]  stored_stamp[DEF_LEVELS];
    logic               stored_seen[DEF_LEVELS];
    logic [TIME_W-1:0]  timeout_ms[TIMEOUT_REGS];

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 46;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;

    priority_color_source_select_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_level        (i_level),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_white_in     (i_white_in),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_white_out    (o_white_out),
        .o_winning_level(o_winning_level),
        .o_shown        (o_shown)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // store the write, then take the first written level that has not expired
    function automatic t_result select_winner(input t_color_write wr);
        t_result            res;
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  limit;
        res = '0;
        stored_color[wr.level] = {wr.white, wr.blue, wr.green, wr.red};
        stored_stamp[wr.level] = wr.now_ms;
        stored_seen[wr.level]  = 1'b1;
        for (int lv = 0; lv < DEF_LEVELS; lv++) begin
            elapsed = wr.now_ms - stored_stamp[lv];
            limit   = (lv < TIMEOUT_REGS) ? timeout_ms[lv] : '0;
            if (!res.shown && stored_seen[lv] && (limit == 0 || elapsed <= limit)) begin
                res.color = stored_color[lv];
                res.level = LVL_OUT_W'(lv);
                res.shown = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic queue_write(input logic [LVL_OUT_W-1:0] lv, input logic [31:0] rgbw,
                               input logic [TIME_W-1:0] now);
        t_color_write wr;
        wr.level  = lv;
        wr.red    = rgbw[31:24];
        wr.green  = rgbw[23:16];
        wr.blue   = rgbw[15:8];
        wr.white  = rgbw[7:0];
        wr.now_ms = now;
        pending_writes.push_back(wr);
    endtask

    task automatic write_reg(input t_timeout_reg idx, input logic [APB_DW-1:0] value);
        timeout_ms[idx] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timeouts(input logic [31:0] t0, input logic [31:0] t1,
                                input logic [31:0] t2, input logic [31:0] t3);
        write_reg(REG_TIMEOUT_L0, t0);
        write_reg(REG_TIMEOUT_L1, t1);
        write_reg(REG_TIMEOUT_L2, t2);
        write_reg(REG_TIMEOUT_L3, t3);
    endtask

    // all writes sent and all colors back, then let the scan pipeline settle
    task automatic wait_drained();
        while (pending_writes.size() != 0 || i_valid || expected_colors.size() != 0)
            @(negedge i_clk);
        repeat (DEF_LEVELS + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_timeout();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(1, 50);
            4: return $urandom_range(1, 400);
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin : drive
        t_color_write nxt;
        t_color_write acc;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                acc.level  = i_level;
                acc.red    = i_red_in;
                acc.green  = i_green_in;
                acc.blue   = i_blue_in;
                acc.white  = i_white_in;
                acc.now_ms = i_now_ms;
                expected_colors.push_back(select_winner(acc));
            end
            if (!i_valid || !o_stall) begin
                if (pending_writes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_writes.pop_front();
                    i_level    <= nxt.level;
                    i_red_in   <= nxt.red;
                    i_green_in <= nxt.green;
                    i_blue_in  <= nxt.blue;
                    i_white_in <= nxt.white;
                    i_now_ms   <= nxt.now_ms;
                    i_valid    <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin : monitor
        t_result want;
        int      hold_left;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_colors.size() == 0) begin
                    $error("color result with no transaction pending");
                    mismatch_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (o_red_out !== want.color[7:0]) begin
                        $error("red_out: expected %0h, got %0h", want.color[7:0], o_red_out);
                        mismatch_count++;
                    end
                    if (o_green_out !== want.color[15:8]) begin
                        $error("green_out: expected %0h, got %0h", want.color[15:8],
                               o_green_out);
                        mismatch_count++;
                    end
                    if (o_blue_out !== want.color[23:16]) begin
                        $error("blue_out: expected %0h, got %0h", want.color[23:16],
                               o_blue_out);
                        mismatch_count++;
                    end
                    if (o_white_out !== want.color[31:24]) begin
                        $error("white_out: expected %0h, got %0h", want.color[31:24],
                               o_white_out);
                        mismatch_count++;
                    end
                    if (o_winning_level !== want.level) begin
                        $error("winning_level: expected %0d, got %0d", want.level,
                               o_winning_level);
                        mismatch_count++;
                    end
                    if (o_shown !== want.shown) begin
                        $error("shown: expected %0b, got %0b", want.shown, o_shown);
                        mismatch_count++;
                    end
                end
                results_seen++;
                // long back-pressure so the core fills and stalls its input
                if (results_seen % 300 == 150)
                    hold_left = 80;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end else begin
            hold_left = 0;
        end
    end

    // watchdog: no transaction of any kind for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] clock_ms;
        logic [31:0]       step;
        for (int lv = 0; lv < DEF_LEVELS; lv++) begin
            stored_color[lv] = '0;
            stored_stamp[lv] = '0;
            stored_seen[lv]  = 1'b0;
        end
        for (int r = 0; r < TIMEOUT_REGS; r++)
            timeout_ms[r] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all timeouts zero: nothing expires; write at time zero still counts
        queue_write(2'd3, 32'h0000_0000, 32'h0000_0000);
        queue_write(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_write(2'd3, 32'h1234_5678, 32'h0000_0005);
        queue_write(2'd0, 32'hA55A_0FF0, 32'h0000_0000);
        queue_write(2'd1, 32'h8001_7FFE, 32'h0000_3039);
        wait_drained();

        // expiry boundaries, fall-through and the wrap of the ms counter
        set_timeouts(32'd10, 32'd20, 32'd30, 32'd40);
        queue_write(2'd0, 32'h0102_0304, 32'd100);
        queue_write(2'd1, 32'h1112_1314, 32'd105);
        queue_write(2'd1, 32'h2122_2324, 32'd110);
        queue_write(2'd1, 32'h3132_3334, 32'd111);
        queue_write(2'd2, 32'h4142_4344, 32'd131);
        queue_write(2'd3, 32'h5152_5354, 32'd132);
        queue_write(2'd3, 32'h6162_6364, 32'd200);
        queue_write(2'd0, 32'hC3C3_3C3C, 32'hFFFF_FFFA);
        queue_write(2'd2, 32'h9966_6699, 32'd3);
        queue_write(2'd3, 32'hDEAD_BEEF, 32'd5);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                set_timeouts(32'd1, 32'd1, 32'd1, 32'd1);
            else if (ph == 1)
                set_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else
                set_timeouts(pick_timeout(), pick_timeout(), pick_timeout(), pick_timeout());

            if (ph == 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 14;
            end else if (ph == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            clock_ms = $urandom_range(0, 1) ? $urandom
                                            : 32'hFFFF_FFFF - $urandom_range(0, 3000);
            for (int k = 0; k < PHASE_WRITES; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // out-of-order time stamp
                    queue_write(LVL_OUT_W'($urandom_range(0, 3)), $urandom, $urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0: step = 0;
                        1: step = $urandom_range(1, 3);
                        default: step = $urandom_range(0, 80);
                    endcase
                    clock_ms += step;
                    queue_write(LVL_OUT_W'($urandom_range(0, 3)), $urandom, clock_ms);
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pcss_pkg.sv
src/pcss_cfg.sv
src/pcss_store.sv
src/pcss_expiry_unit.sv
src/priority_color_source_select_core.sv
tb/testbench.sv
